[sv/text_word_window_splitter_unit_defines.svh]
// Assertion macros for the text word window splitter.
// Included by files that check internal behavior; needs clk and rst_n in scope.
`ifndef TEXT_WORD_WINDOW_SPLITTER_UNIT_DEFINES_SVH
`define TEXT_WORD_WINDOW_SPLITTER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Check that cons holds whenever ante holds
`define TWWS_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("twws implication check failed");
// Check that cond never holds
`define TWWS_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("twws forbidden condition seen");
`else
`define TWWS_ASSERT_IMPLIES(label, ante, cons)
`define TWWS_ASSERT_NEVER(label, cond)
`endif
`endif

[sv/twws_pkg.sv]
// Shared types and constants of the text word window splitter.
// No dependencies; imported by every module of the block but twws_queue.
package twws_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int OUT_OFF_W  = 21;
  localparam int WW_W       = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [WW_W-1:0] WW_RESET = 12'd64;

  // Slot positions in a window bundle: group A is the section closed by a tag
  // change (or a plain word end), group B the close at document end
  localparam int SLOT_A_WIN0 = 0;
  localparam int SLOT_A_WIN1 = 1;
  localparam int SLOT_A_FIN0 = 2;
  localparam int SLOT_A_FIN1 = 3;
  localparam int SLOT_B_WIN0 = 4;
  localparam int SLOT_B_WIN1 = 5;
  localparam int SLOT_B_FIN0 = 6;
  localparam int SLOT_B_FIN1 = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_WORDS = 1'b0,
    REG_SECOND_PASS  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic close_a;   // tag change closes the open section
    logic open_sec;  // a new section opens at this byte
    logic word_end;  // space after non-space ends a word
    logic close_b;   // document end closes the section after this byte
  } cmd_flags_t;

  typedef struct packed {
    logic                 pass_num;
    logic [7:0]           section;
    logic [OUT_OFF_W-1:0] beg_off;
    logic [OUT_OFF_W-1:0] end_off;
  } win_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    win_t [NUM_SLOTS-1:0] slot;
  } bundle_t;

  // Space is 0x20 or 0x09..0x0D
  function automatic logic is_space(logic [7:0] b);
    return b inside {8'h20, [8'h09:8'h0D]};
  endfunction

endpackage

[sv/twws_queue.sv]
// Short command queue between the classifying front and the executing back.
// Flop storage, full flag decoded from the registered count; uses twws_pkg only through its users.
module twws_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;

  function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head      = mem_r[rd_ptr_r];
  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[sv/twws_front.sv]
// Front end: accepts text beats, tracks offset and section, classifies events.
// Depends on twws_pkg (cmd_flags_t, is_space).
module twws_front import twws_pkg::*; #(
  parameter int OFFSET_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_text_byte,
  input  logic [7:0]             in_section_tag,
  input  logic                   in_doc_end,
  input  logic                   q_full,
  output logic                   cmd_push,
  output cmd_flags_t             cmd_flags,
  output logic [7:0]             cmd_old_id,
  output logic [7:0]             cmd_new_id,
  output logic [OFFSET_BITS:0]   cmd_pos,
  output logic [OFFSET_BITS:0]   cmd_pos_next
);

  localparam int OW = OFFSET_BITS + 1;
  localparam logic [OW-1:0] OFF_LIMIT = {1'b1, {OFFSET_BITS{1'b0}}};

  logic [OW-1:0] off_r;
  logic          open_r;
  logic [7:0]    id_r;
  logic          prior_r;

  logic          sp;
  logic          close_a;
  logic          new_open;
  logic [OW-1:0] pos_next;

  // Classify the beat against the open section
  always_comb begin
    sp       = is_space(in_text_byte);
    close_a  = open_r && (in_section_tag != id_r);
    new_open = close_a || !open_r;
    pos_next = (off_r < OFF_LIMIT) ? off_r + 1'b1 : off_r;
  end

  assign in_stall           = q_full;
  assign cmd_push           = in_valid && !q_full;
  assign cmd_flags.close_a  = close_a;
  assign cmd_flags.open_sec = new_open;
  assign cmd_flags.word_end = sp && !new_open && prior_r;
  assign cmd_flags.close_b  = in_doc_end;
  assign cmd_old_id         = id_r;
  assign cmd_new_id         = in_section_tag;
  assign cmd_pos            = off_r;
  assign cmd_pos_next       = pos_next;

  // Advance offset and section state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      open_r  <= 1'b0;
      id_r    <= '0;
      prior_r <= 1'b0;
    end else if (cmd_push) begin
      off_r   <= in_doc_end ? '0 : pos_next;
      open_r  <= !in_doc_end;
      id_r    <= in_section_tag;
      prior_r <= !in_doc_end && !sp;
    end
  end

endmodule

[sv/twws_exec.sv]
// Back end: holds word counters and config, turns one command into a window bundle.
// Depends on twws_pkg (cmd_flags_t, win_t, bundle_t, slot and register codes).
module twws_exec import twws_pkg::*; #(
  parameter int OFFSET_BITS = 20,
  parameter int COUNT_BITS  = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  head_valid,
  input  cmd_flags_t            head_flags,
  input  logic [7:0]            head_old_id,
  input  logic [7:0]            head_new_id,
  input  logic [OFFSET_BITS:0]  head_pos,
  input  logic [OFFSET_BITS:0]  head_pos_next,
  input  logic                  take_ok,
  output logic                  pop,
  output bundle_t               bundle
);

  localparam int OW = OFFSET_BITS + 1;
  localparam int SW = COUNT_BITS + 1;
  localparam int FW = (COUNT_BITS > WW_W) ? COUNT_BITS : WW_W;
  localparam int CW = ((SW > WW_W) ? SW : WW_W) + 1;

  typedef struct packed {
    logic [COUNT_BITS-1:0] fw;
    logic [OW-1:0]         fs;
    logic [SW-1:0]         sw;
    logic [OW-1:0]         ss;
  } cnt_t;

  cnt_t            cnt_r;
  cnt_t            cnt_nxt;
  logic [WW_W-1:0] ww_r;
  logic            en_r;

  cnt_t            cw;
  logic            h0;
  logic            h1;
  logic [OW-1:0]   b0;
  logic [OW-1:0]   b1;

  // One word end: advance both pass counters, cut windows that fill
  function automatic void word_step(input cnt_t c, input logic [OW-1:0] p,
                                    input logic [WW_W-1:0] ww, input logic en,
                                    output cnt_t n, output logic hit0,
                                    output logic hit1, output logic [OW-1:0] beg0,
                                    output logic [OW-1:0] beg1);
    logic [COUNT_BITS-1:0] fw1;
    logic [SW-1:0]         sw1;
    logic signed [CW-1:0]  sx;
    n    = c;
    hit1 = 1'b0;
    fw1  = c.fw + 1'b1;
    hit0 = (ww != '0) && (FW'(fw1) == FW'(ww));
    beg0 = c.fs;
    n.fw = fw1;
    if (hit0) begin
      n.fw = '0;
      n.fs = p;
    end
    sw1  = c.sw + 1'b1;
    n.sw = sw1;
    // Second pass starts counting real words once it reaches zero
    if (sw1 == '0) begin
      n.ss = p;
    end
    beg1 = n.ss;
    sx   = CW'($signed(sw1));
    if ((ww != '0) && (sx == $signed(CW'(ww)))) begin
      hit1 = en;
      n.sw = '0;
      n.ss = p;
    end
  endfunction

  function automatic logic ge_half(logic [SW-1:0] sw, logic [WW_W-1:0] ww);
    return $signed(CW'($signed(sw))) >= $signed(CW'(ww >> 1));
  endfunction

  function automatic win_t mk_win(logic pass_num, logic [7:0] sec,
                                  logic [OW-1:0] b, logic [OW-1:0] e);
    win_t w;
    w.pass_num = pass_num;
    w.section  = sec;
    w.beg_off  = OUT_OFF_W'(b);
    w.end_off  = OUT_OFF_W'(e);
    return w;
  endfunction

  assign pop = head_valid && take_ok;

  // Run the events of one command in model order
  always_comb begin
    cnt_nxt = cnt_r;
    cw      = cnt_r;
    h0      = 1'b0;
    h1      = 1'b0;
    b0      = '0;
    b1      = '0;
    bundle  = '0;
    if (head_flags.close_a) begin
      word_step(cnt_nxt, head_pos, ww_r, en_r, cw, h0, h1, b0, b1);
      cnt_nxt = cw;
      bundle.slot[SLOT_A_WIN0] = mk_win(1'b0, head_old_id, b0, head_pos);
      bundle.mask[SLOT_A_WIN0] = h0;
      bundle.slot[SLOT_A_WIN1] = mk_win(1'b1, head_old_id, b1, head_pos);
      bundle.mask[SLOT_A_WIN1] = h1;
      bundle.slot[SLOT_A_FIN0] = mk_win(1'b0, head_old_id, cnt_nxt.fs, head_pos);
      bundle.mask[SLOT_A_FIN0] = 1'b1;
      bundle.slot[SLOT_A_FIN1] = mk_win(1'b1, head_old_id, cnt_nxt.ss, head_pos);
      bundle.mask[SLOT_A_FIN1] = en_r && ge_half(cnt_nxt.sw, ww_r);
    end
    // Section open: second pass starts half a window behind
    if (head_flags.open_sec) begin
      cnt_nxt.fw = '0;
      cnt_nxt.fs = head_pos;
      cnt_nxt.sw = -SW'(ww_r >> 1);
      cnt_nxt.ss = head_pos;
    end
    if (head_flags.word_end) begin
      word_step(cnt_nxt, head_pos, ww_r, en_r, cw, h0, h1, b0, b1);
      cnt_nxt = cw;
      bundle.slot[SLOT_A_WIN0] = mk_win(1'b0, head_new_id, b0, head_pos);
      bundle.mask[SLOT_A_WIN0] = h0;
      bundle.slot[SLOT_A_WIN1] = mk_win(1'b1, head_new_id, b1, head_pos);
      bundle.mask[SLOT_A_WIN1] = h1;
    end
    if (head_flags.close_b) begin
      word_step(cnt_nxt, head_pos_next, ww_r, en_r, cw, h0, h1, b0, b1);
      cnt_nxt = cw;
      bundle.slot[SLOT_B_WIN0] = mk_win(1'b0, head_new_id, b0, head_pos_next);
      bundle.mask[SLOT_B_WIN0] = h0;
      bundle.slot[SLOT_B_WIN1] = mk_win(1'b1, head_new_id, b1, head_pos_next);
      bundle.mask[SLOT_B_WIN1] = h1;
      bundle.slot[SLOT_B_FIN0] = mk_win(1'b0, head_new_id, cnt_nxt.fs, head_pos_next);
      bundle.mask[SLOT_B_FIN0] = 1'b1;
      bundle.slot[SLOT_B_FIN1] = mk_win(1'b1, head_new_id, cnt_nxt.ss, head_pos_next);
      bundle.mask[SLOT_B_FIN1] = en_r && ge_half(cnt_nxt.sw, ww_r);
    end
  end

  // Commit counters when a command leaves the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (pop) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ww_r <= WW_RESET;
      en_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WINDOW_WORDS: ww_r <= cfg_wdata[WW_W-1:0];
        REG_SECOND_PASS:  en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

[sv/twws_drain.sv]
// Back end output side: holds one window bundle and sends its windows one beat each.
// Depends on twws_pkg (win_t, bundle_t).
module twws_drain import twws_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 bundle_load,
  input  bundle_t              bundle,
  output logic                 take_ok,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_pass_number,
  output logic [7:0]           out_window_section,
  output logic [OUT_OFF_W-1:0] out_begin_offset,
  output logic [OUT_OFF_W-1:0] out_end_offset,
  output logic                 out_run_last
);

  logic [NUM_SLOTS-1:0] mask_r;
  win_t [NUM_SLOTS-1:0] slot_r;
  logic                 out_valid_r;
  win_t                 out_win_r;
  logic                 out_last_r;

  logic                 can_out;
  logic                 fire;
  logic [NUM_SLOTS-1:0] low;
  logic [NUM_SLOTS-1:0] rest;
  logic [NUM_SLOTS-1:0] mask_left;
  win_t                 picked;

  // Pick the lowest pending slot
  always_comb begin
    low     = mask_r & (~mask_r + 1'b1);
    rest    = mask_r & ~low;
    can_out = !out_valid_r || !out_stall;
    fire    = can_out && (mask_r != '0);
    picked  = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (low[i]) begin
        picked = slot_r[i];
      end
    end
    mask_left = fire ? rest : mask_r;
  end

  assign take_ok            = (mask_left == '0);
  assign out_valid          = out_valid_r;
  assign out_pass_number    = out_win_r.pass_num;
  assign out_window_section = out_win_r.section;
  assign out_begin_offset   = out_win_r.beg_off;
  assign out_end_offset     = out_win_r.end_off;
  assign out_run_last       = out_last_r;

  // Hold bundle payload
  always_ff @(posedge clk) begin
    if (bundle_load) begin
      slot_r <= bundle.slot;
    end
    if (fire) begin
      out_win_r  <= picked;
      out_last_r <= (rest == '0);
    end
  end

  // Pending mask and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= bundle_load ? bundle.mask : mask_left;
      if (can_out) begin
        out_valid_r <= (mask_r != '0);
      end
    end
  end

endmodule

[sv/text_word_window_splitter_unit.sv]
// Path: a window passes the command queue, the pending mask and the output register.
// Throughput: one text beat per cycle while each beat yields at most one window
// and out_stall is low; a beat yielding several windows holds the output side until all
// are sent, and the 4-entry command queue absorbs the burst before in_stall rises.
// Reset: synchronous active-low rst_n clears the control state but not the data storage;
// window_words resets to 64 and the second pass to off.
`include "text_word_window_splitter_unit_defines.svh"
module text_word_window_splitter_unit import twws_pkg::*; #(
  parameter int OFFSET_BITS = 20,
  parameter int COUNT_BITS  = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_text_byte,
  input  logic [7:0]            in_section_tag,
  input  logic                  in_doc_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_pass_number,
  output logic [7:0]            out_window_section,
  output logic [OUT_OFF_W-1:0]  out_begin_offset,
  output logic [OUT_OFF_W-1:0]  out_end_offset,
  output logic                  out_run_last
);

  localparam int OW = OFFSET_BITS + 1;
  localparam int QW = $bits(cmd_flags_t) + 16 + 2 * OW;

  logic          q_full;
  logic          q_not_empty;
  logic          q_pop;
  logic [QW-1:0] q_head;

  logic          cmd_push;
  cmd_flags_t    cmd_flags;
  logic [7:0]    cmd_old_id;
  logic [7:0]    cmd_new_id;
  logic [OW-1:0] cmd_pos;
  logic [OW-1:0] cmd_pos_next;

  cmd_flags_t    hd_flags;
  logic [7:0]    hd_old_id;
  logic [7:0]    hd_new_id;
  logic [OW-1:0] hd_pos;
  logic [OW-1:0] hd_pos_next;

  logic          take_ok;
  bundle_t       bundle;

  twws_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .in_section_tag (in_section_tag),
    .in_doc_end     (in_doc_end),
    .q_full         (q_full),
    .cmd_push       (cmd_push),
    .cmd_flags      (cmd_flags),
    .cmd_old_id     (cmd_old_id),
    .cmd_new_id     (cmd_new_id),
    .cmd_pos        (cmd_pos),
    .cmd_pos_next   (cmd_pos_next)
  );

  twws_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .din       ({cmd_flags, cmd_old_id, cmd_new_id, cmd_pos, cmd_pos_next}),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // Split the queue head back into command fields
  assign {hd_flags, hd_old_id, hd_new_id, hd_pos, hd_pos_next} = q_head;

  twws_exec #(.OFFSET_BITS(OFFSET_BITS), .COUNT_BITS(COUNT_BITS)) u_exec (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .head_valid    (q_not_empty),
    .head_flags    (hd_flags),
    .head_old_id   (hd_old_id),
    .head_new_id   (hd_new_id),
    .head_pos      (hd_pos),
    .head_pos_next (hd_pos_next),
    .take_ok       (take_ok),
    .pop           (q_pop),
    .bundle        (bundle)
  );

  twws_drain u_drain (
    .clk                (clk),
    .rst_n              (rst_n),
    .bundle_load        (q_pop),
    .bundle             (bundle),
    .take_ok            (take_ok),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pass_number    (out_pass_number),
    .out_window_section (out_window_section),
    .out_begin_offset   (out_begin_offset),
    .out_end_offset     (out_end_offset),
    .out_run_last       (out_run_last)
  );

  // A tag change opens a new section, which masks the word end, so no word end can ride with it
  `TWWS_ASSERT_NEVER(a_close_with_word, cmd_push && cmd_flags.close_a && cmd_flags.word_end)
  // Every section close yields a first-pass final window
  `TWWS_ASSERT_IMPLIES(a_final_on_tag_close, q_pop && hd_flags.close_a, bundle.mask[SLOT_A_FIN0])
  `TWWS_ASSERT_IMPLIES(a_final_on_doc_end, q_pop && hd_flags.close_b, bundle.mask[SLOT_B_FIN0])

endmodule

[bench/text_word_window_splitter_unit_tb.sv]
// Testbench for text_word_window_splitter_unit: directed table, random text, back-pressure.
// Depends on twws_pkg and the block itself; a built-in predictor or typed rows check every window.
`timescale 1ns / 1ps
module text_word_window_splitter_unit_tb;
  import twws_pkg::*;

  localparam int OFFSET_BITS = 20;
  localparam logic [OUT_OFF_W-1:0] OFFSET_CEIL = 21'd1 << OFFSET_BITS;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 5000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_BEATS = 40;

  typedef struct packed {
    logic                 pass_num;
    logic [7:0]           section;
    logic [OUT_OFF_W-1:0] beg_off;
    logic [OUT_OFF_W-1:0] end_off;
    logic                 last;
  } window_rec_t;

  typedef struct packed {
    logic                  is_cfg;
    cfg_reg_t              reg_idx;
    logic [CFG_DATA_W-1:0] value;
    logic [7:0]            text;
    logic [7:0]            tag;
    logic                  doc_end;
    logic                  typed;
    window_rec_t           win;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_text_byte;
  logic [7:0]            in_section_tag;
  logic                  in_doc_end;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_pass_number;
  logic [7:0]            out_window_section;
  logic [OUT_OFF_W-1:0]  out_begin_offset;
  logic [OUT_OFF_W-1:0]  out_end_offset;
  logic                  out_run_last;

  text_word_window_splitter_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_text_byte       (in_text_byte),
    .in_section_tag     (in_section_tag),
    .in_doc_end         (in_doc_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pass_number    (out_pass_number),
    .out_window_section (out_window_section),
    .out_begin_offset   (out_begin_offset),
    .out_end_offset     (out_end_offset),
    .out_run_last       (out_run_last)
  );

  // Predictor copy of the registers and the splitter state
  logic [WW_W-1:0]      win_words;
  logic                 overlap_on;
  logic [OUT_OFF_W-1:0] text_offset;
  logic [7:0]           cur_section;
  logic                 section_live;
  logic                 after_word_char;
  logic [WW_W-1:0]      main_count;
  logic [OUT_OFF_W-1:0] main_start;
  logic [WW_W:0]        shift_count;
  logic [OUT_OFF_W-1:0] shift_start;

  window_rec_t step_windows[$];
  window_rec_t pending_windows[$];
  stim_row_t   directed_rows[$];

  int          err_count;
  int          quiet_cycles;
  bit          hold_req;
  bit          tx_gaps_on;
  bit          rx_gaps_on;
  logic [7:0]  cur_tag;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_blank(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  task automatic add_window(input logic pass, input logic [OUT_OFF_W-1:0] b,
                            input logic [OUT_OFF_W-1:0] e);
    window_rec_t w;
    w = '0;
    w.pass_num = pass;
    w.section = cur_section;
    w.beg_off = b;
    w.end_off = e;
    step_windows.push_back(w);
  endtask

  // Count one word ending at p; cut windows of both passes when full
  task automatic count_word(input logic [OUT_OFF_W-1:0] p);
    int s;
    main_count = main_count + 1'b1;
    if (win_words != 0 && main_count == win_words) begin
      add_window(1'b0, main_start, p);
      main_count = '0;
      main_start = p;
    end
    shift_count = shift_count + 1'b1;
    s = int'($signed(shift_count));
    if (s == 0) shift_start = p;
    if (win_words != 0 && s == int'(win_words)) begin
      if (overlap_on) add_window(1'b1, shift_start, p);
      shift_count = '0;
      shift_start = p;
    end
  endtask

  // Close the section: phantom word, final windows
  task automatic close_sec(input logic [OUT_OFF_W-1:0] e);
    count_word(e);
    add_window(1'b0, main_start, e);
    if (overlap_on && int'($signed(shift_count)) >= int'(win_words >> 1))
      add_window(1'b1, shift_start, e);
    section_live = 1'b0;
    after_word_char = 1'b0;
  endtask

  // Work out the windows one text beat causes
  task automatic predict_windows(input logic [7:0] b, input logic [7:0] tg, input logic de);
    bit blank;
    blank = is_blank(b);
    step_windows.delete();
    if (section_live && tg != cur_section) close_sec(text_offset);
    if (!section_live) begin
      section_live = 1'b1;
      cur_section = tg;
      after_word_char = 1'b0;
      main_count = '0;
      main_start = text_offset;
      shift_count = '0 - (WW_W + 1)'(win_words >> 1);
      shift_start = text_offset;
    end
    if (blank && after_word_char) count_word(text_offset);
    after_word_char = !blank;
    if (text_offset < OFFSET_CEIL) text_offset = text_offset + 1'b1;
    if (de) begin
      close_sec(text_offset);
      text_offset = '0;
    end
  endtask

  // Offer one beat, hold it until accepted, then queue its windows
  task automatic send_byte(input logic [7:0] b, input logic [7:0] tg, input logic de,
                           input logic typed, input window_rec_t tw);
    window_rec_t w;
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_section_tag <= tg;
    in_doc_end <= de;
    do @(posedge clk); while (in_stall);
    predict_windows(b, tg, de);
    if (typed) begin
      pending_windows.push_back(tw);
    end else begin
      for (int i = 0; i < step_windows.size(); i++) begin
        w = step_windows[i];
        w.last = (i == step_windows.size() - 1);
        pending_windows.push_back(w);
      end
    end
    // Drop valid for a random gap now and then
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? int'($urandom_range(15, 40))
                                        : int'($urandom_range(1, 3));
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every window is in and the pipe is empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_windows.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WINDOW_WORDS: win_words = val[WW_W-1:0];
      REG_SECOND_PASS:  overlap_on = val[0];
      default: ;
    endcase
  endtask

  function automatic stim_row_t byte_row(input logic [7:0] b, input logic [7:0] tg,
                                         input logic de);
    stim_row_t r;
    r = '0;
    r.text = b;
    r.tag = tg;
    r.doc_end = de;
    return r;
  endfunction

  // Beat whose single first-pass window starts at offset zero
  function automatic stim_row_t typed_row(input logic [7:0] b, input logic [7:0] tg,
                                          input logic [OUT_OFF_W-1:0] e);
    stim_row_t r;
    r = byte_row(b, tg, 1'b1);
    r.typed = 1'b1;
    r.win.section = tg;
    r.win.end_off = e;
    r.win.last = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.value = v;
    return r;
  endfunction

  // Random text: mostly words and blanks, some noise, section and document ends
  task automatic send_random_text();
    logic [7:0] b;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      b = 8'($urandom_range(0, 255));
    end else if (pick < 8) begin
      pick = $urandom_range(0, 5);
      b = (pick == 5) ? 8'h20 : 8'h09 + 8'(pick);
    end else begin
      do b = 8'($urandom_range(0, 255)); while (is_blank(b));
    end
    if ($urandom_range(0, 14) == 0) cur_tag = 8'($urandom_range(0, 255));
    send_byte(b, cur_tag, $urandom_range(0, 29) == 0, 1'b0, '0);
  endtask

  // Receiver: random stalls, or one long hold-off on request
  initial begin : receiver
    int run_left;
    bit stalling;
    run_left = 0;
    stalling = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else begin
        if (run_left == 0) begin
          stalling = !stalling;
          if (stalling)
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                   : $urandom_range(1, 3);
          else
            run_left = $urandom_range(1, 30);
        end
        out_stall <= stalling && rx_gaps_on;
        run_left--;
      end
    end
  end

  // Compare each accepted window with the oldest expectation
  always @(posedge clk) begin : check_windows
    window_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_windows.size() == 0) begin
        $error("window with none expected: section %0h begin %0d end %0d",
               out_window_section, out_begin_offset, out_end_offset);
        err_count++;
      end else begin
        want = pending_windows.pop_front();
        if (out_pass_number !== want.pass_num) begin
          $error("pass_number: expected %0d, got %0d", want.pass_num, out_pass_number);
          err_count++;
        end
        if (out_window_section !== want.section) begin
          $error("window_section: expected %0h, got %0h", want.section, out_window_section);
          err_count++;
        end
        if (out_begin_offset !== want.beg_off) begin
          $error("begin_offset: expected %0d, got %0d", want.beg_off, out_begin_offset);
          err_count++;
        end
        if (out_end_offset !== want.end_off) begin
          $error("end_offset: expected %0d, got %0d", want.end_off, out_end_offset);
          err_count++;
        end
        if (out_run_last !== want.last) begin
          $error("run_last: expected %0d, got %0d", want.last, out_run_last);
          err_count++;
        end
      end
    end
  end

  // Count cycles in which no beat moves on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[text_word_window_splitter_unit] ERROR");
    $finish;
  end

  initial begin : main
    stim_row_t r;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_text_byte = '0;
    in_section_tag = '0;
    in_doc_end = 1'b0;
    err_count = 0;
    quiet_cycles = 0;
    hold_req = 1'b0;
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    cur_tag = '0;
    win_words = WW_RESET;
    overlap_on = 1'b0;
    text_offset = '0;
    cur_section = '0;
    section_live = 1'b0;
    after_word_char = 1'b0;
    main_count = '0;
    main_start = '0;
    shift_count = '0;
    shift_start = '0;

    // Directed beats: reset config, byte and tag extremes, blank edges
    directed_rows.push_back(typed_row(8'h61, 8'h00, 21'd1));
    directed_rows.push_back(typed_row(8'h00, 8'hFF, 21'd1));
    directed_rows.push_back(typed_row(8'h20, 8'h00, 21'd1));
    directed_rows.push_back(byte_row(8'hFF, 8'h80, 1'b0));
    directed_rows.push_back(byte_row(8'h09, 8'h80, 1'b0));
    directed_rows.push_back(byte_row(8'h0D, 8'h80, 1'b0));
    directed_rows.push_back(byte_row(8'h08, 8'h80, 1'b0));
    directed_rows.push_back(byte_row(8'h0E, 8'h80, 1'b0));
    directed_rows.push_back(byte_row(8'h0A, 8'h80, 1'b0));
    directed_rows.push_back(byte_row(8'h0B, 8'h80, 1'b0));
    directed_rows.push_back(byte_row(8'h80, 8'h80, 1'b0));
    directed_rows.push_back(byte_row(8'h0C, 8'h80, 1'b0));
    directed_rows.push_back(byte_row(8'h21, 8'h80, 1'b0));
    directed_rows.push_back(byte_row(8'h20, 8'h7F, 1'b0));
    // One-word windows with both passes; section stays open across the change
    directed_rows.push_back(cfg_row(REG_WINDOW_WORDS, 12'd1));
    directed_rows.push_back(cfg_row(REG_SECOND_PASS, 12'd1));
    directed_rows.push_back(byte_row(8'h61, 8'h01, 1'b0));
    directed_rows.push_back(byte_row(8'h62, 8'h02, 1'b1));
    // Zero window size: closing windows only
    directed_rows.push_back(cfg_row(REG_WINDOW_WORDS, 12'd0));
    directed_rows.push_back(byte_row(8'h78, 8'h03, 1'b0));
    directed_rows.push_back(byte_row(8'h20, 8'h03, 1'b0));
    directed_rows.push_back(byte_row(8'h79, 8'h03, 1'b0));
    directed_rows.push_back(byte_row(8'h20, 8'h03, 1'b1));
    // Largest window: second-pass final window never reaches half
    directed_rows.push_back(cfg_row(REG_WINDOW_WORDS, 12'd4095));
    directed_rows.push_back(typed_row(8'h7A, 8'hAA, 21'd1));
    directed_rows.push_back(cfg_row(REG_WINDOW_WORDS, 12'd3));
    directed_rows.push_back(byte_row(8'h61, 8'h04, 1'b0));
    directed_rows.push_back(byte_row(8'h20, 8'h04, 1'b0));
    directed_rows.push_back(byte_row(8'h62, 8'h04, 1'b0));
    directed_rows.push_back(byte_row(8'h20, 8'h04, 1'b0));
    directed_rows.push_back(byte_row(8'h63, 8'h04, 1'b1));

    // Reset
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.is_cfg) begin
        settle();
        write_reg(r.reg_idx, r.value);
      end else begin
        send_byte(r.text, r.tag, r.doc_end, r.typed, r.win);
      end
    end

    // Random phases, each with fresh register values
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      case (ph)
        0:       write_reg(REG_WINDOW_WORDS, 12'd1);
        1:       write_reg(REG_WINDOW_WORDS, 12'd4095);
        2:       write_reg(REG_WINDOW_WORDS, 12'd0);
        default: write_reg(REG_WINDOW_WORDS, CFG_DATA_W'($urandom_range(2, 9)));
      endcase
      write_reg(REG_SECOND_PASS, (ph == 0) ? 12'd1 : CFG_DATA_W'($urandom_range(0, 1)));
      for (int n = 0; n < PHASE_BEATS; n++) begin
        send_random_text();
        if ($urandom_range(0, 99) == 0) settle();
      end
    end

    // Hold the receiver off while beats keep coming, so the block backs up
    settle();
    write_reg(REG_WINDOW_WORDS, 12'd1);
    write_reg(REG_SECOND_PASS, 12'd1);
    tx_gaps_on = 1'b0;
    hold_req = 1'b1;
    for (int n = 0; n < 40; n++)
      send_byte((n % 2) ? 8'h20 : 8'h6D, (n < 20) ? 8'h11 : 8'h12, n == 39, 1'b0, '0);

    // Drain and report
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("[text_word_window_splitter_unit] OK");
    else
      $display("[text_word_window_splitter_unit] ERROR");
    $finish;
  end

endmodule
